[sv/pbis_pkg.sv]
// Shared types, constants and helpers for the palette bilinear image scaler.
// Used by every module of the block but pbis_ram; depends on nothing else.
`timescale 1ns / 1ps

package pbis_pkg;

  // Source byte store: 16-bit pixel addresses, wrapping over the whole store.
  localparam int SRC_AW    = 16;
  localparam int SRC_DEPTH = 1 << SRC_AW;

  // Default palette size.
  localparam int DEF_PALETTE_ENTRIES = 256;

  // Configuration register indexes (byte address = 4 * index).
  localparam logic [2:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH   = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_PAL_COUNT   = 3'd4;
  localparam logic [2:0] REG_BOTTOM_UP   = 3'd5;

  // Item kinds carried in tuser.
  typedef enum logic [1:0] {
    KIND_PAL_WRITE = 2'd0,
    KIND_PIX_WRITE = 2'd1,
    KIND_RENDER    = 2'd2,
    KIND_NONE      = 2'd3
  } kind_t;

  // One input transaction, unpacked.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pal_index;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [15:0] pixel_address;
    logic [7:0]  pixel_byte;
    logic [10:0] dst_x;
    logic [10:0] dst_y;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [10:0] out_x;
    logic [10:0] out_y;
    logic        index_error;
  } result_t;

  // Configuration register contents.
  typedef struct packed {
    logic [8:0]  src_width;
    logic [8:0]  src_height;
    logic [11:0] dst_width;
    logic [11:0] dst_height;
    logic [8:0]  pal_count;
    logic        bottom_up;
  } cfg_t;

  // Request to the serial divider. A long request yields a 20-bit quotient,
  // a short one an 8-bit quotient (dividend known to be below divisor * 256).
  typedef struct packed {
    logic        start;
    logic        long_mode;
    logic [19:0] dividend;
    logic [11:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [19:0] quot;
    logic [11:0] rem;
  } div_rsp_t;

  // Pick one color channel out of a {red, green, blue} palette word.
  function automatic logic [7:0] chan_sel(input logic [23:0] rgb, input logic [1:0] ch);
    logic [7:0] v;
    case (ch)
      2'd0:    v = rgb[23:16];
      2'd1:    v = rgb[15:8];
      default: v = rgb[7:0];
    endcase
    return v;
  endfunction

endpackage

[sv/pbis_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the palette and the source image store.
`timescale 1ns / 1ps

module pbis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/pbis_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on pbis_pkg for the request and response structs.
`timescale 1ns / 1ps

module pbis_div (
  input  logic               clk,
  input  logic               rst,
  input  pbis_pkg::div_req_t req,
  output pbis_pkg::div_rsp_t rsp
);
  import pbis_pkg::*;

  logic        busy;
  logic        done;
  logic        long_r;
  logic [4:0]  cnt;
  logic [11:0] rem;
  logic [19:0] q;
  logic [11:0] den;

  logic [12:0] partial;
  logic [12:0] diff;
  logic        qbit;
  logic [11:0] rem_next;

  // One trial subtraction per cycle.
  always_comb begin
    partial  = {rem, q[19]};
    diff     = partial - {1'b0, den};
    qbit     = ~diff[12];
    rem_next = qbit ? diff[11:0] : partial[11:0];
  end

  // Control: count steps and pulse done after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.long_mode ? 5'd20 : 5'd8;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: short divisions skip the leading quotient bits known to be zero.
  always_ff @(posedge clk) begin
    if (req.start) begin
      den    <= req.divisor;
      long_r <= req.long_mode;
      rem    <= req.long_mode ? 12'd0 : req.dividend[19:8];
      q      <= req.long_mode ? req.dividend : {req.dividend[7:0], 12'd0};
    end else if (busy) begin
      rem <= rem_next;
      q   <= {q[18:0], qbit};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = long_r ? q : {12'd0, q[7:0]};
  assign rsp.rem  = rem;

endmodule

[sv/pbis_front.sv]
// Front end: accepts input transactions, drops unknown kinds, queues the rest.
// Depends on pbis_pkg for the item type.
`timescale 1ns / 1ps

module pbis_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [79:0]     s_tdata,
  input  logic [1:0]      s_tuser,
  output logic            q_valid,
  output pbis_pkg::item_t q_item,
  input  logic            q_pop
);
  import pbis_pkg::*;

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      in_item;
  logic       push;

  // Unpack the transaction fields.
  always_comb begin
    in_item.kind          = kind_t'(s_tuser);
    in_item.pal_index     = s_tdata[7:0];
    in_item.red_in        = s_tdata[15:8];
    in_item.green_in      = s_tdata[23:16];
    in_item.blue_in       = s_tdata[31:24];
    in_item.pixel_address = s_tdata[47:32];
    in_item.pixel_byte    = s_tdata[55:48];
    in_item.dst_x         = s_tdata[66:56];
    in_item.dst_y         = s_tdata[77:67];
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready && (in_item.kind != KIND_NONE);
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];

  // Two-entry queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

endmodule

[sv/pbis_back.sv]
// Back end: applies store writes and runs the render sequence for each pixel.
// Depends on pbis_pkg, pbis_ram (palette and source store) and an external pbis_div.
`timescale 1ns / 1ps

module pbis_back #(
  parameter int PALETTE_ENTRIES = pbis_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  pbis_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  pbis_pkg::item_t    q_item,
  output logic               q_pop,
  output pbis_pkg::div_req_t div_req,
  input  pbis_pkg::div_rsp_t div_rsp,
  output logic               res_valid,
  output pbis_pkg::result_t  res,
  input  logic               res_ready
);
  import pbis_pkg::*;

  localparam int         PAL_AW    = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_XDIV  = 12'b000000000010,
    ST_XWAIT = 12'b000000000100,
    ST_YDIV  = 12'b000000001000,
    ST_YWAIT = 12'b000000010000,
    ST_ADDR  = 12'b000000100000,
    ST_SRD   = 12'b000001000000,
    ST_PRD   = 12'b000010000000,
    ST_LMUL  = 12'b000100000000,
    ST_LDIV  = 12'b001000000000,
    ST_LWAIT = 12'b010000000000,
    ST_OUT   = 12'b100000000000
  } state_t;

  state_t      state;
  logic [10:0] dx;
  logic [10:0] dy;
  logic [19:0] mulx;
  logic [19:0] muly;
  logic [19:0] sx0;
  logic [11:0] txn;
  logic [19:0] sy0;
  logic [11:0] tyn;
  logic [15:0] addr [4];
  logic [7:0]  idx [4];
  logic [23:0] qv [4];
  logic [2:0]  cnt;
  logic        err;
  logic [1:0]  ch;
  logic [1:0]  sub;
  logic [7:0]  r0;
  logic [7:0]  r1;
  logic [7:0]  col [3];
  logic [19:0] num;
  logic [11:0] den;

  logic [11:0] dw;
  logic [11:0] dh;
  logic [9:0]  stride;
  logic [19:0] sx1;
  logic [19:0] sy1;
  logic [15:0] row0;
  logic [15:0] row1;
  logic [1:0]  prev;
  logic        idx_bad;
  logic [7:0]  la;
  logic [7:0]  lb;
  logic [11:0] ln;
  logic [11:0] ld;
  logic [20:0] lnum;
  logic [11:0] oy;

  logic        src_we;
  logic [7:0]  src_rdata;
  logic        pal_we;
  logic [23:0] pal_rdata;

  // Effective sizes and source geometry.
  always_comb begin
    dw     = (cfg.dst_width == 12'd0) ? 12'd1 : cfg.dst_width;
    dh     = (cfg.dst_height == 12'd0) ? 12'd1 : cfg.dst_height;
    stride = {8'((({1'b0, cfg.src_width} + 10'd3) >> 2)), 2'b00} ;
    sx1    = ((21'(sx0) + 21'd1) < 21'(cfg.src_width)) ? sx0 + 20'd1 : sx0;
    sy1    = ((21'(sy0) + 21'd1) < 21'(cfg.src_height)) ? sy0 + 20'd1 : sy0;
    row0   = 16'(sy0[15:0] * stride);
    row1   = 16'(sy1[15:0] * stride);
    prev   = 2'(cnt - 3'd1);
    idx_bad = ({1'b0, idx[prev]} >= cfg.pal_count) || ({1'b0, idx[prev]} >= PAL_LIMIT);
    oy     = cfg.bottom_up ? (dh - 12'd1 - {1'b0, dy}) : {1'b0, dy};
  end

  // Lerp operand selection: two passes along x, then one along y.
  always_comb begin
    case (sub)
      2'd0: begin
        la = chan_sel(qv[0], ch);
        lb = chan_sel(qv[1], ch);
      end
      2'd1: begin
        la = chan_sel(qv[2], ch);
        lb = chan_sel(qv[3], ch);
      end
      default: begin
        la = r0;
        lb = r1;
      end
    endcase
    ln   = (sub == 2'd2) ? tyn : txn;
    ld   = (sub == 2'd2) ? dh : dw;
    lnum = 21'(ln * lb) + 21'((ld - ln) * la);
  end

  // Divider requests.
  always_comb begin
    div_req.start     = (state == ST_XDIV) || (state == ST_YDIV) || (state == ST_LDIV);
    div_req.long_mode = (state != ST_LDIV);
    unique case (state)
      ST_XDIV: begin
        div_req.dividend = mulx;
        div_req.divisor  = dw;
      end
      ST_YDIV: begin
        div_req.dividend = muly;
        div_req.divisor  = dh;
      end
      default: begin
        div_req.dividend = num;
        div_req.divisor  = den;
      end
    endcase
  end

  assign q_pop  = (state == ST_IDLE) && q_valid;
  assign src_we = q_pop && (q_item.kind == KIND_PIX_WRITE);
  assign pal_we = q_pop && (q_item.kind == KIND_PAL_WRITE) &&
                  ({1'b0, q_item.pal_index} < PAL_LIMIT);

  // Source image store.
  pbis_ram #(
    .WIDTH (8),
    .DEPTH (SRC_DEPTH)
  ) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (q_item.pixel_address),
    .wdata (q_item.pixel_byte),
    .raddr (addr[cnt[1:0]]),
    .rdata (src_rdata)
  );

  // Palette store.
  pbis_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (q_item.pal_index[PAL_AW-1:0]),
    .wdata ({q_item.red_in, q_item.green_in, q_item.blue_in}),
    .raddr (idx[cnt[1:0]][PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  // Render sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      // The output register fills from ST_OUT and empties on acceptance.
      if ((state == ST_OUT) && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid && (q_item.kind == KIND_RENDER)) begin
            state <= ST_XDIV;
          end
        end
        ST_XDIV:  state <= ST_XWAIT;
        ST_XWAIT: begin
          if (div_rsp.done) begin
            state <= ST_YDIV;
          end
        end
        ST_YDIV:  state <= ST_YWAIT;
        ST_YWAIT: begin
          if (div_rsp.done) begin
            state <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          cnt   <= 3'd0;
          state <= ST_SRD;
        end
        ST_SRD: begin
          if (cnt == 3'd4) begin
            cnt   <= 3'd0;
            state <= ST_PRD;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_PRD: begin
          if (cnt == 3'd4) begin
            cnt   <= 3'd0;
            state <= (err || idx_bad) ? ST_OUT : ST_LMUL;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_LMUL:  state <= ST_LDIV;
        ST_LDIV:  state <= ST_LWAIT;
        ST_LWAIT: begin
          if (div_rsp.done) begin
            state <= ((sub == 2'd2) && (ch == 2'd2)) ? ST_OUT : ST_LMUL;
          end
        end
        ST_OUT: begin
          if (!res_valid || res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Render datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        dx   <= q_item.dst_x;
        dy   <= q_item.dst_y;
        mulx <= 20'(q_item.dst_x * cfg.src_width);
        muly <= 20'(q_item.dst_y * cfg.src_height);
        err  <= 1'b0;
        ch   <= 2'd0;
        sub  <= 2'd0;
      end
      ST_XWAIT: begin
        if (div_rsp.done) begin
          sx0 <= div_rsp.quot;
          txn <= div_rsp.rem;
        end
      end
      ST_YWAIT: begin
        if (div_rsp.done) begin
          sy0 <= div_rsp.quot;
          tyn <= div_rsp.rem;
        end
      end
      ST_ADDR: begin
        addr[0] <= row0 + sx0[15:0];
        addr[1] <= row0 + sx1[15:0];
        addr[2] <= row1 + sx0[15:0];
        addr[3] <= row1 + sx1[15:0];
      end
      ST_SRD: begin
        if (cnt != 3'd0) begin
          idx[prev] <= src_rdata;
        end
      end
      ST_PRD: begin
        if (cnt != 3'd0) begin
          qv[prev] <= pal_rdata;
          if (idx_bad) begin
            err <= 1'b1;
          end
        end
      end
      ST_LMUL: begin
        num <= lnum[19:0];
        den <= ld;
      end
      ST_LWAIT: begin
        if (div_rsp.done) begin
          case (sub)
            2'd0:    r0 <= div_rsp.quot[7:0];
            2'd1:    r1 <= div_rsp.quot[7:0];
            default: col[ch] <= div_rsp.quot[7:0];
          endcase
          if (sub == 2'd2) begin
            sub <= 2'd0;
            ch  <= ch + 2'd1;
          end else begin
            sub <= sub + 2'd1;
          end
        end
      end
      ST_OUT: begin
        if (!res_valid || res_ready) begin
          res.out_red     <= err ? 8'd0 : col[0];
          res.out_green   <= err ? 8'd0 : col[1];
          res.out_blue    <= err ? 8'd0 : col[2];
          res.out_x       <= dx;
          res.out_y       <= oy[10:0];
          res.index_error <= err;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/palette_bilinear_image_scaler_unit.sv]
// Palette bilinear image scaler: a 256-color indexed source image and its palette
// are loaded by write transactions; each render transaction returns one scaled
// destination pixel. A render runs two 20-step coordinate divisions and nine
// 8-step interpolation divisions on one shared serial divider, plus four source
// reads and four palette reads on memories with one write and one read port.
// A render with a bad index skips the interpolation.
// Two transactions can queue in front of the back end, and a finished result
// waits in the output register; the back end stalls only when a second result is
// ready while the first is still held. Neighbor indexes at or above the palette
// count register or the palette size flag index_error with zero color. Depends on pbis_pkg,
// pbis_front, pbis_back, pbis_div and pbis_ram.
`timescale 1ns / 1ps

module palette_bilinear_image_scaler_unit #(
  parameter int PALETTE_ENTRIES = pbis_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // pal_index[7:0], red_in[15:8], green_in[23:16], blue_in[31:24],
  // pixel_address[47:32], pixel_byte[55:48], dst_x[66:56], dst_y[77:67], zero pad
  input  logic [79:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]  s_tuser,
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_x[34:24], out_y[45:35], zero pad
  output logic [47:0] m_tdata,
  // index_error
  output logic        m_tuser
);
  import pbis_pkg::*;

  cfg_t     cfg;
  logic     cfg_we;
  logic     q_valid;
  item_t    q_item;
  logic     q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;
  result_t  res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width   <= 9'd1;
      cfg.src_height  <= 9'd1;
      cfg.dst_width   <= 12'd1;
      cfg.dst_height  <= 12'd1;
      cfg.pal_count   <= 9'd256;
      cfg.bottom_up   <= 1'b1;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_SRC_WIDTH:   cfg.src_width   <= pwdata[8:0];
        REG_SRC_HEIGHT:  cfg.src_height  <= pwdata[8:0];
        REG_DST_WIDTH:   cfg.dst_width   <= pwdata[11:0];
        REG_DST_HEIGHT:  cfg.dst_height  <= pwdata[11:0];
        REG_PAL_COUNT:   cfg.pal_count   <= pwdata[8:0];
        REG_BOTTOM_UP:   cfg.bottom_up   <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[4:2])
      REG_SRC_WIDTH:   prdata = {23'd0, cfg.src_width};
      REG_SRC_HEIGHT:  prdata = {23'd0, cfg.src_height};
      REG_DST_WIDTH:   prdata = {20'd0, cfg.dst_width};
      REG_DST_HEIGHT:  prdata = {20'd0, cfg.dst_height};
      REG_PAL_COUNT:   prdata = {23'd0, cfg.pal_count};
      REG_BOTTOM_UP:   prdata = {31'd0, cfg.bottom_up};
      default:         prdata = 32'd0;
    endcase
  end

  pbis_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pbis_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pbis_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .res_valid (m_tvalid),
    .res       (res),
    .res_ready (m_tready)
  );

  // Pack the result transaction.
  assign m_tdata = {2'b00, res.out_y, res.out_x, res.out_blue, res.out_green, res.out_red};
  assign m_tuser = res.index_error;

endmodule

[dv/palette_bilinear_image_scaler_unit_test.sv]
// Self-checking testbench for the palette bilinear image scaler.
// Uses pbis_pkg for kinds, register indexes and result layout; needs only the RTL.
`timescale 1ns / 1ps

module palette_bilinear_image_scaler_unit_test;
  import pbis_pkg::*;

  localparam int IDLE_LIMIT   = 6000;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_CYCLES = 800;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        m_tuser;

  palette_bilinear_image_scaler_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Directed stimulus row: an item, and optionally its expected pixel typed in.
  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } row_t;

  // Rows assume the reset configuration and a loaded palette.
  localparam int N_ROWS = 14;
  row_t rows [N_ROWS] = '{
    '{'{KIND_PAL_WRITE, 8'd0,   8'h00, 8'h00, 8'h00, 16'h0, 8'h0, 11'd0, 11'd0}, 0, '0},
    '{'{KIND_PAL_WRITE, 8'd255, 8'hff, 8'hff, 8'hff, 16'h0, 8'h0, 11'd0, 11'd0}, 0, '0},
    '{'{KIND_PAL_WRITE, 8'd1,   8'hff, 8'h00, 8'h80, 16'h0, 8'h0, 11'd0, 11'd0}, 0, '0},
    '{'{KIND_PIX_WRITE, 8'd0, 8'h0, 8'h0, 8'h0, 16'h0000, 8'd0,   11'd0, 11'd0}, 0, '0},
    '{'{KIND_RENDER,    8'd0, 8'h0, 8'h0, 8'h0, 16'h0, 8'h0, 11'd0, 11'd0}, 1,
      '{8'h00, 8'h00, 8'h00, 11'd0, 11'd0, 1'b0}},
    '{'{KIND_PIX_WRITE, 8'd0, 8'h0, 8'h0, 8'h0, 16'h0000, 8'd255, 11'd0, 11'd0}, 0, '0},
    '{'{KIND_RENDER,    8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 8'hff, 11'd0, 11'd0}, 1,
      '{8'hff, 8'hff, 8'hff, 11'd0, 11'd0, 1'b0}},
    '{'{KIND_PIX_WRITE, 8'd0, 8'h0, 8'h0, 8'h0, 16'h0000, 8'd1,   11'd0, 11'd0}, 0, '0},
    '{'{KIND_RENDER,    8'd0, 8'h0, 8'h0, 8'h0, 16'h0, 8'h0, 11'd0, 11'd0}, 1,
      '{8'hff, 8'h00, 8'h80, 11'd0, 11'd0, 1'b0}},
    '{'{KIND_NONE,      8'd1, 8'h11, 8'h22, 8'h33, 16'h0000, 8'd7, 11'd0, 11'd0}, 0, '0},
    '{'{KIND_PIX_WRITE, 8'd0, 8'h0, 8'h0, 8'h0, 16'hffff, 8'hab,  11'd0, 11'd0}, 0, '0},
    '{'{KIND_RENDER,    8'd0, 8'h0, 8'h0, 8'h0, 16'h0, 8'h0, 11'd0, 11'd0}, 0, '0},
    '{'{KIND_PAL_WRITE, 8'd1,   8'h12, 8'h34, 8'h56, 16'h0, 8'h0, 11'd0, 11'd0}, 0, '0},
    '{'{KIND_RENDER,    8'd0, 8'h0, 8'h0, 8'h0, 16'h0, 8'h0, 11'd0, 11'd0}, 0, '0}
  };

  // Phase settings: src_width, src_height, dst_width, dst_height, palette count, bottom_up.
  localparam int N_PHASES = 10;
  int unsigned phase_cfg [N_PHASES][6] = '{
    '{4, 3, 7, 5, 256, 1},
    '{1, 1, 2048, 2048, 256, 0},
    '{256, 1, 300, 2, 256, 1},
    '{1, 200, 1, 40, 256, 0},
    '{5, 6, 13, 2, 3, 1},
    '{3, 2, 9, 9, 0, 0},
    '{0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0}
  };

  // Shadow of the block: configuration and both stores.
  int unsigned cur_sw, cur_sh, cur_dw, cur_dh, cur_colors, cur_flip;
  logic [23:0] palette_mem [256];
  logic [7:0]  source_mem [SRC_DEPTH];

  result_t pixel_q [$];
  int      fail_count;
  int      pixel_count;
  int      error_pixel_count;
  int      idle_cycles;
  bit      quiet_sender;
  bit      quiet_receiver;

  // Clock and watchdog.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned blend(int unsigned a, int unsigned b,
                                        int unsigned n, int unsigned d);
    return (n * b + (d - n) * a) / d;
  endfunction

  // Expected scaled pixel for one render transaction.
  function automatic result_t scale_pixel(item_t it);
    int unsigned dw, dh, stride, sx0, sx1, sy0, sy1, txn, tyn, shift;
    int unsigned addr [4];
    int unsigned c [4];
    int unsigned r0, r1, v;
    logic [7:0]  ix;
    logic [23:0] q [4];
    logic [31:0] oy;
    bit          bad;
    result_t     r;
    dw = (cur_dw != 0) ? cur_dw : 1;
    dh = (cur_dh != 0) ? cur_dh : 1;
    stride = ((cur_sw + 3) / 4) * 4;
    sx0 = it.dst_x * cur_sw / dw;
    txn = (it.dst_x * cur_sw) % dw;
    sy0 = it.dst_y * cur_sh / dh;
    tyn = (it.dst_y * cur_sh) % dh;
    sx1 = (sx0 + 1 < cur_sw) ? sx0 + 1 : sx0;
    sy1 = (sy0 + 1 < cur_sh) ? sy0 + 1 : sy0;
    addr[0] = sy0 * stride + sx0;
    addr[1] = sy0 * stride + sx1;
    addr[2] = sy1 * stride + sx0;
    addr[3] = sy1 * stride + sx1;
    bad = 1'b0;
    for (int k = 0; k < 4; k++) begin
      ix = source_mem[addr[k] % SRC_DEPTH];
      if (ix >= cur_colors) begin
        bad = 1'b1;
        q[k] = '0;
      end else begin
        q[k] = palette_mem[ix];
      end
    end
    r = '0;
    if (!bad) begin
      for (int ch = 0; ch < 3; ch++) begin
        shift = 16 - 8 * ch;
        for (int k = 0; k < 4; k++) c[k] = (q[k] >> shift) & 8'hff;
        r0 = blend(c[0], c[1], txn, dw);
        r1 = blend(c[2], c[3], txn, dw);
        v = blend(r0, r1, tyn, dh) & 8'hff;
        case (ch)
          0: r.out_red = v[7:0];
          1: r.out_green = v[7:0];
          default: r.out_blue = v[7:0];
        endcase
      end
    end
    oy = cur_flip ? (dh - 1 - it.dst_y) : it.dst_y;
    r.out_x = it.dst_x;
    r.out_y = oy[10:0];
    r.index_error = bad;
    return r;
  endfunction

  // Register write over the configuration port; updates the shadow copy too.
  task automatic reg_write(logic [2:0] idx, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:   cur_sw = value & 9'h1ff;
      REG_SRC_HEIGHT:  cur_sh = value & 9'h1ff;
      REG_DST_WIDTH:   cur_dw = value & 12'hfff;
      REG_DST_HEIGHT:  cur_dh = value & 12'hfff;
      REG_PAL_COUNT:   cur_colors = value & 9'h1ff;
      default:         cur_flip = value & 1;
    endcase
  endtask

  // Offer one input transaction, wait for its acceptance and record its effect.
  task automatic send_item(item_t it, bit typed, result_t res);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {2'b00, it.dst_y, it.dst_x, it.pixel_byte, it.pixel_address,
                 it.blue_in, it.green_in, it.red_in, it.pal_index};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (it.kind)
      KIND_PAL_WRITE: palette_mem[it.pal_index] = {it.red_in, it.green_in, it.blue_in};
      KIND_PIX_WRITE: source_mem[it.pixel_address] = it.pixel_byte;
      KIND_RENDER:    pixel_q.push_back(typed ? res : scale_pixel(it));
      default: ;
    endcase
  endtask

  function automatic item_t noise_item();
    item_t it;
    it = 80'({$urandom, $urandom, $urandom});
    return it;
  endfunction

  // Wait for every pending pixel, then let a possible trailing write settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: random back-pressure, one long hold-off, field-by-field compare.
  initial begin
    int      gap;
    result_t want;
    m_tready = 1'b0;
    forever begin
      if (pixel_count == 30) begin
        m_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else begin
        gap = quiet_receiver ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      pixel_count++;
      if (pixel_count % 60 == 0) quiet_receiver = ~quiet_receiver;
      if (m_tuser) error_pixel_count++;
      if (pixel_q.size() == 0) begin
        $error("pixel transaction with no expectation pending");
        fail_count++;
      end else begin
        want = pixel_q.pop_front();
        if (m_tdata[7:0] !== want.out_red) begin
          $error("out_red expected %0h got %0h", want.out_red, m_tdata[7:0]);
          fail_count++;
        end
        if (m_tdata[15:8] !== want.out_green) begin
          $error("out_green expected %0h got %0h", want.out_green, m_tdata[15:8]);
          fail_count++;
        end
        if (m_tdata[23:16] !== want.out_blue) begin
          $error("out_blue expected %0h got %0h", want.out_blue, m_tdata[23:16]);
          fail_count++;
        end
        if (m_tdata[34:24] !== want.out_x) begin
          $error("out_x expected %0d got %0d", want.out_x, m_tdata[34:24]);
          fail_count++;
        end
        if (m_tdata[45:35] !== want.out_y) begin
          $error("out_y expected %0d got %0d", want.out_y, m_tdata[45:35]);
          fail_count++;
        end
        if (m_tuser !== want.index_error) begin
          $error("index_error expected %0b got %0b", want.index_error, m_tuser);
          fail_count++;
        end
      end
    end
  end

  // Stimulus: palette load, directed table, then randomized phases.
  initial begin
    item_t       it;
    int unsigned stride, pick;
    int unsigned cfg [6];
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = KIND_NONE;
    fail_count = 0; pixel_count = 0; error_pixel_count = 0; idle_cycles = 0;
    quiet_sender = 1'b0; quiet_receiver = 1'b0;
    cur_sw = 1; cur_sh = 1; cur_dw = 1; cur_dh = 1; cur_colors = 256; cur_flip = 1;
    foreach (palette_mem[i]) palette_mem[i] = '0;
    foreach (source_mem[i]) source_mem[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every palette entry is written once, so any index may be looked up later.
    for (int i = 0; i < 256; i++) begin
      it = noise_item();
      it.kind = KIND_PAL_WRITE;
      it.pal_index = i;
      send_item(it, 1'b0, '0);
    end
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);

    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      cfg = phase_cfg[p];
      if (cfg[0] == 0) begin
        cfg[0] = $urandom_range(1, 8);
        cfg[1] = $urandom_range(1, 8);
        cfg[2] = $urandom_range(1, 64);
        cfg[3] = $urandom_range(1, 64);
        cfg[4] = $urandom_range(0, 256);
        cfg[5] = $urandom_range(0, 1);
      end
      reg_write(REG_SRC_WIDTH, cfg[0]);
      reg_write(REG_SRC_HEIGHT, cfg[1]);
      reg_write(REG_DST_WIDTH, cfg[2]);
      reg_write(REG_DST_HEIGHT, cfg[3]);
      reg_write(REG_PAL_COUNT, cfg[4]);
      reg_write(REG_BOTTOM_UP, cfg[5]);
      quiet_sender = (p % 3 == 1);
      stride = ((cur_sw + 3) / 4) * 4;

      // Fill the visible source image so every render reads written bytes.
      for (int y = 0; y < cur_sh; y++) begin
        for (int x = 0; x < cur_sw; x++) begin
          it = noise_item();
          it.kind = KIND_PIX_WRITE;
          it.pixel_address = y * stride + x;
          send_item(it, 1'b0, '0);
        end
      end

      // Mostly renders in range, mixed with image edits, palette edits and noise.
      for (int n = 0; n < 20; n++) begin
        it = noise_item();
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          it.kind = KIND_RENDER;
          it.dst_x = $urandom_range(0, cur_dw - 1);
          it.dst_y = $urandom_range(0, cur_dh - 1);
        end else if (pick < 82) begin
          it.kind = KIND_PIX_WRITE;
          it.pixel_address = $urandom_range(0, cur_sh - 1) * stride +
                             $urandom_range(0, cur_sw - 1);
        end else if (pick < 93) begin
          it.kind = KIND_PAL_WRITE;
        end else if (pick < 97) begin
          it.kind = KIND_PIX_WRITE;
        end else begin
          it.kind = KIND_NONE;
        end
        send_item(it, 1'b0, '0);
      end
    end

    wait_idle();
    $display("Covered %0d scaled pixels, %0d of them with a bad palette index,",
             pixel_count, error_pixel_count);
    $display("over %0d register settings with random idling on both streams.", N_PHASES + 1);
    if (fail_count == 0 && pixel_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
